>>> sv/gnss_frame_checksum_checker_assert.svh
// ----------------------------------------------------------------------------
// gnss_frame_checksum_checker_assert.svh
// Assertion macros for the GNSS frame checksum checker.
// ----------------------------------------------------------------------------
`ifndef GNSS_FRAME_CHECKSUM_CHECKER_ASSERT_SVH
`define GNSS_FRAME_CHECKSUM_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define GFCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gfcc: implication check failed");

// condition must never hold out of reset
`define GFCC_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("gfcc: forbidden condition seen");

`else

`define GFCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GFCC_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> sv/gfcc_pkg.sv
// ----------------------------------------------------------------------------
// gfcc_pkg
// Types, constants and class lookup for the GNSS frame checksum checker.
// ----------------------------------------------------------------------------
package gfcc_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_CKSUM   = 2'd2
  } status_t;

  // byte positions within a frame
  localparam logic [4:0] POS_MAX       = 5'd31;
  localparam logic [4:0] POS_CLASS     = 5'd2;
  localparam logic [4:0] POS_ID        = 5'd3;
  localparam logic [4:0] POS_LEN_LO    = 5'd4;
  localparam logic [4:0] POS_LEN_HI    = 5'd5;
  localparam logic [4:0] POS_SUM_START = 5'd4;   // older held byte enters sum
  localparam logic [4:0] POS_FIX_LO    = 5'd14;  // payload byte 8
  localparam logic [4:0] POS_FIX_HI    = 5'd17;  // payload byte 11
  localparam logic [4:0] POS_SHORT_MAX = 5'd7;   // last byte at or below: too short
  localparam logic [4:0] POS_FIX_MIN   = 5'd19;  // frame of 20 bytes or more

  localparam logic [7:0]  NAV_CLASS       = 8'h01;
  localparam logic [7:0]  NAV_ID_FIX      = 8'h03;
  localparam logic [15:0] FIX_PAYLOAD_LEN = 16'd16;

  typedef struct packed {
    logic [7:0]  sum_a;
    logic [7:0]  sum_b;
    logic [7:0]  held_old;
    logic [7:0]  held_new;
    logic [4:0]  pos;
    logic [7:0]  frame_class;
    logic [7:0]  frame_id;
    logic [15:0] payload_len;
    logic [31:0] cand_fix;
  } frame_sum_t;

  function automatic logic class_known(input logic [7:0] c);
    logic known;
    case (c) inside
      8'h01, 8'h02, 8'h04, 8'h05, 8'h06, 8'h09,
      8'h0A, 8'h0D, 8'h13, 8'h21, 8'h27: known = 1'b1;
      default:                           known = 1'b0;
    endcase
    return known;
  endfunction

endpackage

>>> sv/gnss_frame_checksum_checker.sv
// ----------------------------------------------------------------------------
// gnss_frame_checksum_checker
// Flow: a byte is registered, then processed; a frame's result is loaded
//   into the result register when its last byte leaves the input register.
// Throughput: one byte per cycle while no last byte waits on a stalled result,
//   set by the single process stage between the input and result registers.
// Reset: synchronous, active low; clears checksum, header captures, the
//   stored time to first fix and both valid flags.
// ----------------------------------------------------------------------------
module gnss_frame_checksum_checker (
  input  logic        clk,
  input  logic        rst_n,
  // byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_is_last,
  // result channel, one item per frame
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_fix_time_updated,
  output logic [31:0] out_fix_time
);
  import gfcc_pkg::*;
  `include "gnss_frame_checksum_checker_assert.svh"

  // input register
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       accept;
  logic       advance;

  // result register
  logic        out_vld_r, out_vld_nxt;
  status_t     out_status_r;
  logic        out_upd_r;
  logic [31:0] out_fix_r;
  logic        out_take;
  logic        load_result;

  // latched time to first fix, kept across frames
  logic [31:0] fix_time_r;

  frame_sum_t frame;
  status_t    status;
  logic       latch_fix;

  // The only thing that can hold the process stage is a last byte that
  // needs a result slot while the previous result is still stalled.
  // Non-last bytes always go through.
  assign in_stall    = in_vld_r && in_last_r && out_vld_r && out_stall;
  assign accept      = in_valid && !in_stall;
  assign advance     = in_vld_r && !in_stall;
  assign load_result = advance && in_last_r;
  assign out_take    = out_vld_r && !out_stall;

  gfcc_frame_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .data_byte (in_byte_r),
    .is_last   (in_last_r),
    .frame_o   (frame)
  );

  // Status priority: short frame, then checksum, then class lookup.
  always_comb begin
    if (frame.pos <= POS_SHORT_MAX) begin
      status = ST_INVALID;
    end else if (frame.held_old != frame.sum_a || frame.held_new != frame.sum_b) begin
      status = ST_CKSUM;
    end else if (!class_known(frame.frame_class)) begin
      status = ST_INVALID;
    end else begin
      status = ST_OK;
    end
  end

  // Fix latch needs the navigation fix message with a full payload that
  // really sits ahead of the checksum bytes.
  assign latch_fix = (status == ST_OK) &&
                     (frame.frame_class == NAV_CLASS) &&
                     (frame.frame_id == NAV_ID_FIX) &&
                     (frame.payload_len == FIX_PAYLOAD_LEN) &&
                     (frame.pos >= POS_FIX_MIN);

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (load_result) begin
      out_vld_nxt = 1'b1;
    end else if (out_take) begin
      out_vld_nxt = 1'b0;
    end
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      out_vld_r  <= 1'b0;
      fix_time_r <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (load_result && latch_fix) begin
        fix_time_r <= frame.cand_fix;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_data_byte;
      in_last_r <= in_is_last;
    end
    if (load_result) begin
      out_status_r <= status;
      out_upd_r    <= latch_fix;
      out_fix_r    <= latch_fix ? frame.cand_fix : fix_time_r;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_status           = out_status_r;
  assign out_fix_time_updated = out_upd_r;
  assign out_fix_time         = out_fix_r;

  // an update is only ever reported on a good frame
  `GFCC_ASSERT_IMP(a_upd_ok, clk, rst_n, out_vld_r && out_upd_r, out_status_r == ST_OK)
  // backpressure reaches the byte side only through a pending last byte
  `GFCC_ASSERT_IMP(a_stall_cause, clk, rst_n, in_stall,
                   in_vld_r && in_last_r && out_vld_r && out_stall)
  // the reserved status code never leaves the block
  `GFCC_ASSERT_NEVER(a_no_rsvd, clk, rst_n, out_vld_r && out_status_r != ST_OK &&
                     out_status_r != ST_INVALID && out_status_r != ST_CKSUM)

endmodule

>>> sv/gfcc_frame_track.sv
// ----------------------------------------------------------------------------
// gfcc_frame_track
// Per-frame state: Fletcher-8 sums, two-byte hold, position and header
// captures. Presents the view after the current byte; clears on last byte.
// ----------------------------------------------------------------------------
module gfcc_frame_track (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  logic [7:0]             data_byte,
  input  logic                   is_last,
  output gfcc_pkg::frame_sum_t   frame_o
);
  import gfcc_pkg::*;

  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  held_old_r, held_new_r;
  logic [4:0]  pos_r, pos_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] len_r, len_nxt;
  logic [31:0] cand_r, cand_nxt;
  logic [4:0]  fix_off;

  assign fix_off = pos_r - POS_FIX_LO;

  always_comb begin
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    if (pos_r >= POS_SUM_START) begin
      sum_a_nxt = sum_a_r + held_old_r;
      sum_b_nxt = sum_b_r + sum_a_nxt;
    end

    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    cand_nxt  = cand_r;
    if (pos_r == POS_CLASS) begin
      class_nxt = data_byte;
    end else if (pos_r == POS_ID) begin
      id_nxt = data_byte;
    end else if (pos_r == POS_LEN_LO) begin
      len_nxt[7:0] = data_byte;
    end else if (pos_r == POS_LEN_HI) begin
      len_nxt[15:8] = data_byte;
    end else if (pos_r >= POS_FIX_LO && pos_r <= POS_FIX_HI) begin
      case (fix_off[1:0])
        2'd0:    cand_nxt[7:0]   = data_byte;
        2'd1:    cand_nxt[15:8]  = data_byte;
        2'd2:    cand_nxt[23:16] = data_byte;
        default: cand_nxt[31:24] = data_byte;
      endcase
    end

    pos_nxt = (pos_r == POS_MAX) ? pos_r : pos_r + 5'd1;
  end

  assign frame_o = '{
    sum_a:       sum_a_nxt,
    sum_b:       sum_b_nxt,
    held_old:    held_new_r,
    held_new:    data_byte,
    pos:         pos_r,
    frame_class: class_nxt,
    frame_id:    id_nxt,
    payload_len: len_nxt,
    cand_fix:    cand_nxt
  };

  always_ff @(posedge clk) begin
    if (!rst_n || (step && is_last)) begin
      sum_a_r    <= '0;
      sum_b_r    <= '0;
      held_old_r <= '0;
      held_new_r <= '0;
      pos_r      <= '0;
      class_r    <= '0;
      id_r       <= '0;
      len_r      <= '0;
      cand_r     <= '0;
    end else if (step) begin
      sum_a_r    <= sum_a_nxt;
      sum_b_r    <= sum_b_nxt;
      held_old_r <= held_new_r;
      held_new_r <= data_byte;
      pos_r      <= pos_nxt;
      class_r    <= class_nxt;
      id_r       <= id_nxt;
      len_r      <= len_nxt;
      cand_r     <= cand_nxt;
    end
  end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for gnss_frame_checksum_checker. Frames are built byte
// by byte (good, corrupted, short, long, unknown class, fix-time frames and
// noise) and pushed through the valid/stall byte channel. Each accepted byte
// is run through a local copy of the frame checker; every frame verdict the
// block returns is matched field by field against the oldest prediction.
// ----------------------------------------------------------------------------
import gfcc_pkg::*;

// class codes listed by the binary protocol, one byte each
localparam logic [87:0] KNOWN_CLASS_LIST = {
  8'h01, 8'h02, 8'h04, 8'h05, 8'h06, 8'h09, 8'h0A, 8'h0D, 8'h13, 8'h21, 8'h27
};
localparam int NUM_KNOWN_CLASSES = 11;
localparam int SHORT_FRAME_MAX   = 8;   // frames this long or shorter are invalid
localparam int FIX_FRAME_MIN     = 20;  // fix bytes must sit before the checksum
localparam int MAX_REPORTS       = 10;

typedef struct {
  status_t     status;
  logic        fix_updated;
  logic [31:0] fix_time;
} frame_verdict_t;

// Tracks the frame in flight and holds the verdicts still owed by the block.
class frame_verdict_board;
  logic [7:0]  sum_a, sum_b;
  logic [7:0]  held_old, held_new;
  logic [4:0]  pos;
  logic [7:0]  cls, fid;
  logic [15:0] plen;
  logic [31:0] cand_fix, stored_fix;

  frame_verdict_t pending_verdicts[$];

  int mismatches, bytes_taken, frames_closed;
  int n_ok, n_invalid, n_cksum, n_latched;

  function new();
    stored_fix    = '0;
    mismatches    = 0;
    bytes_taken   = 0;
    frames_closed = 0;
    n_ok          = 0;
    n_invalid     = 0;
    n_cksum       = 0;
    n_latched     = 0;
    clear_frame();
  endfunction

  function void clear_frame();
    sum_a    = '0;
    sum_b    = '0;
    held_old = '0;
    held_new = '0;
    pos      = '0;
    cls      = '0;
    fid      = '0;
    plen     = '0;
    cand_fix = '0;
  endfunction

  function bit class_listed(logic [7:0] c);
    int k;
    for (k = 0; k < NUM_KNOWN_CLASSES; k++) begin
      if (KNOWN_CLASS_LIST[8*k +: 8] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  // one accepted byte; a last byte closes the frame and queues its verdict
  function void take_byte(logic [7:0] b, logic last);
    logic [4:0]     p;
    int             flen;
    int             sh;
    frame_verdict_t v;
    p = pos;
    bytes_taken++;
    // the older held byte drops out of the hold and into the sums
    if (p >= POS_SUM_START) begin
      sum_a = sum_a + held_old;
      sum_b = sum_b + sum_a;
    end
    held_old = held_new;
    held_new = b;

    if (p == POS_CLASS) begin
      cls = b;
    end else if (p == POS_ID) begin
      fid = b;
    end else if (p == POS_LEN_LO) begin
      plen[7:0] = b;
    end else if (p == POS_LEN_HI) begin
      plen[15:8] = b;
    end else if (p >= POS_FIX_LO && p <= POS_FIX_HI) begin
      sh = (int'(p) - int'(POS_FIX_LO)) * 8;
      cand_fix[sh +: 8] = b;
    end

    if (!last) begin
      if (pos != POS_MAX) pos = pos + 5'd1;
      return;
    end

    flen          = int'(p) + 1;
    v.fix_updated = 1'b0;
    if (flen <= SHORT_FRAME_MAX) begin
      v.status = ST_INVALID;
    end else if (held_old != sum_a || held_new != sum_b) begin
      v.status = ST_CKSUM;
    end else if (!class_listed(cls)) begin
      v.status = ST_INVALID;
    end else begin
      v.status = ST_OK;
      if (cls == NAV_CLASS && fid == NAV_ID_FIX && plen == FIX_PAYLOAD_LEN &&
          flen >= FIX_FRAME_MIN) begin
        stored_fix    = cand_fix;
        v.fix_updated = 1'b1;
      end
    end
    v.fix_time = stored_fix;
    pending_verdicts.push_back(v);

    frames_closed++;
    case (v.status)
      ST_OK:      n_ok++;
      ST_INVALID: n_invalid++;
      default:    n_cksum++;
    endcase
    if (v.fix_updated) n_latched++;
    clear_frame();
  endfunction

  function void match_verdict(logic [1:0] st, logic upd, logic [31:0] fix);
    frame_verdict_t v;
    if (pending_verdicts.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("[%0t] unexpected verdict: status=%0d upd=%0b fix=%h",
                 $realtime, st, upd, fix);
      return;
    end
    v = pending_verdicts.pop_front();
    if (st !== v.status || upd !== v.fix_updated || fix !== v.fix_time) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display({"[%0t] verdict mismatch: status exp %0d got %0d, ",
                  "upd exp %0b got %0b, fix exp %h got %h"},
                 $realtime, v.status, st, v.fix_updated, upd, v.fix_time, fix);
    end
  endfunction

  function void flag_leftovers();
    if (pending_verdicts.size() != 0) begin
      mismatches++;
      $display("%0d verdict(s) never returned", pending_verdicts.size());
    end
  endfunction
endclass

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] SYNC_1   = 8'hB5;
  localparam logic [7:0] SYNC_2   = 8'h62;
  localparam logic [7:0] CLS_SEC  = 8'h27;
  localparam logic [7:0] CLS_MON  = 8'h0A;
  localparam logic [7:0] CLS_NONE = 8'h00;
  localparam logic [7:0] CLS_ALL1 = 8'hFF;
  localparam logic [7:0] ID_OTHER = 8'h02;

  // Quiet-cycle limit. Worst case is a run of receiver stalls at 73% or a
  // drain pause; the limit leaves a wide margin.
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;    // result register loads when the last byte leaves the input register
  localparam int RAND_BYTES   = 115;  // per idle phase, three phases
  localparam int RAND_FRAMES  = 6;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_is_last;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        out_fix_time_updated;
  logic [31:0] out_fix_time;

  int send_idle_pct = 14;
  int recv_idle_pct = 73;

  frame_verdict_board sb = new();
  logic [7:0] frame_bytes[$];   // frame under construction

  gnss_frame_checksum_checker dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_data_byte         (in_data_byte),
    .in_is_last           (in_is_last),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_fix_time_updated (out_fix_time_updated),
    .out_fix_time         (out_fix_time)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------- frames
  // header: sync pair (mostly the real one), class, id, length little-endian
  function automatic void start_frame(logic [7:0] c, logic [7:0] id, logic [15:0] len);
    frame_bytes = {};
    if ($urandom_range(7) == 0) begin
      frame_bytes.push_back(8'($urandom));
      frame_bytes.push_back(8'($urandom));
    end else begin
      frame_bytes.push_back(SYNC_1);
      frame_bytes.push_back(SYNC_2);
    end
    frame_bytes.push_back(c);
    frame_bytes.push_back(id);
    frame_bytes.push_back(len[7:0]);
    frame_bytes.push_back(len[15:8]);
  endfunction

  // payload of n bytes; payload bytes 8..11 carry fix, the rest random
  function automatic void add_payload(int n, logic [31:0] fix);
    int k;
    for (k = 0; k < n; k++) begin
      if (k >= 8 && k <= 11) frame_bytes.push_back(fix[(k-8)*8 +: 8]);
      else                   frame_bytes.push_back(8'($urandom));
    end
  endfunction

  // trailing sums; a corrupted frame gets one bit flipped from the class on
  function automatic void add_cksum(bit corrupt);
    logic [7:0] a, b;
    int         k;
    a = '0;
    b = '0;
    for (k = 2; k < frame_bytes.size(); k++) begin
      a = a + frame_bytes[k];
      b = b + a;
    end
    frame_bytes.push_back(a);
    frame_bytes.push_back(b);
    if (corrupt) begin
      k = $urandom_range(frame_bytes.size() - 1, 2);
      frame_bytes[k] = frame_bytes[k] ^ (8'h01 << $urandom_range(7));
    end
  endfunction

  function automatic logic [7:0] pick_known_class();
    return KNOWN_CLASS_LIST[8*$urandom_range(NUM_KNOWN_CLASSES - 1) +: 8];
  endfunction

  function automatic logic [7:0] pick_unknown_class();
    logic [7:0] c;
    do c = 8'($urandom); while (sb.class_listed(c));
    return c;
  endfunction

  function automatic logic [31:0] pick_fix_time();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // ------------------------------------------------------------- drivers
  // Entered and left at a falling edge. Random idle cycles ahead of the
  // item, then hold it until an edge sees in_stall low.
  task automatic send_byte(input logic [7:0] d, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_data_byte = d;
    in_is_last   = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.take_byte(d, last);
    @(negedge clk);
  endtask

  task automatic send_frame();
    int k;
    for (k = 0; k < frame_bytes.size(); k++)
      send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
  endtask

  // sender holds off until every owed verdict is back
  task automatic drain_verdicts();
    in_valid = 1'b0;
    while (sb.pending_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic run_directed();
    // single byte that is also the last
    frame_bytes = {CLS_ALL1};
    send_frame();
    // eight bytes with a correct checksum: still too short
    start_frame(CLS_SEC, 8'h00, 16'd0);
    add_cksum(1'b0);
    send_frame();
    // shortest good frame, then the same with a broken sum
    start_frame(CLS_SEC, 8'hFF, 16'd1);
    add_payload(1, '0);
    add_cksum(1'b0);
    send_frame();
    start_frame(CLS_SEC, 8'hFF, 16'd1);
    add_payload(1, '0);
    add_cksum(1'b1);
    send_frame();
    // unknown class, good sum; unknown class, bad sum (checksum wins)
    start_frame(CLS_NONE, 8'h00, 16'd1);
    add_payload(1, '0);
    add_cksum(1'b0);
    send_frame();
    start_frame(CLS_ALL1, 8'hFF, 16'hFFFF);
    add_payload(2, '0);
    add_cksum(1'b1);
    send_frame();
    // fix latch with all ones, then all zeros
    start_frame(NAV_CLASS, NAV_ID_FIX, FIX_PAYLOAD_LEN);
    add_payload(16, 32'hFFFF_FFFF);
    add_cksum(1'b0);
    send_frame();
    start_frame(NAV_CLASS, NAV_ID_FIX, FIX_PAYLOAD_LEN);
    add_payload(16, 32'h0000_0000);
    add_cksum(1'b0);
    send_frame();
    // wrong id: good frame, no latch
    start_frame(NAV_CLASS, ID_OTHER, FIX_PAYLOAD_LEN);
    add_payload(16, 32'hA5A5_5A5A);
    add_cksum(1'b0);
    send_frame();
    // length says 16 but frame is cut: 19 bytes no latch, 20 bytes latches
    start_frame(NAV_CLASS, NAV_ID_FIX, FIX_PAYLOAD_LEN);
    add_payload(11, 32'h1234_5678);
    add_cksum(1'b0);
    send_frame();
    start_frame(NAV_CLASS, NAV_ID_FIX, FIX_PAYLOAD_LEN);
    add_payload(12, 32'h8765_4321);
    add_cksum(1'b0);
    send_frame();
    // long frame, position saturates, sums keep running
    start_frame(CLS_MON, 8'h04, 16'd40);
    add_payload(40, '0);
    add_cksum(1'b0);
    send_frame();
    drain_verdicts();
  endtask

  task automatic send_random_frame();
    int kind;
    int n;
    int k;
    kind = $urandom_range(99);
    if (kind < 40) begin
      // good frame, known class, small payload
      n = $urandom_range(12, 1);
      start_frame(pick_known_class(), 8'($urandom), 16'(n));
      add_payload(n, $urandom);
      add_cksum(1'b0);
    end else if (kind < 55) begin
      // fix frame, sometimes with the wrong id or length field
      start_frame(NAV_CLASS,
                  ($urandom_range(4) == 0) ? 8'($urandom) : NAV_ID_FIX,
                  ($urandom_range(4) == 0) ? 16'($urandom) : FIX_PAYLOAD_LEN);
      add_payload(16, pick_fix_time());
      add_cksum(1'b0);
    end else if (kind < 65) begin
      n = $urandom_range(16, 1);
      start_frame(($urandom_range(3) == 0) ? pick_unknown_class() : pick_known_class(),
                  8'($urandom), 16'(n));
      add_payload(n, pick_fix_time());
      add_cksum(1'b1);
    end else if (kind < 73) begin
      n = $urandom_range(10, 1);
      start_frame(pick_unknown_class(), 8'($urandom), 16'(n));
      add_payload(n, '0);
      add_cksum(1'b0);
    end else if (kind < 81) begin
      // short frame, half of them look like a real header
      n = $urandom_range(8, 1);
      if ($urandom_range(1) == 0) begin
        start_frame(pick_known_class(), 8'($urandom), 16'd0);
        add_cksum(1'b0);
        while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
      end else begin
        frame_bytes = {};
        for (k = 0; k < n; k++) frame_bytes.push_back(8'($urandom));
      end
    end else if (kind < 88) begin
      n = $urandom_range(40, 20);
      start_frame(pick_known_class(), 8'($urandom), 16'(n));
      add_payload(n, $urandom);
      add_cksum(1'b0);
    end else if (kind < 94) begin
      // fix frame cut around the point where the fix bytes still fit
      n = $urandom_range(13, 8);
      start_frame(NAV_CLASS, NAV_ID_FIX, FIX_PAYLOAD_LEN);
      add_payload(n, pick_fix_time());
      add_cksum(1'b0);
    end else begin
      n = $urandom_range(30, 1);
      frame_bytes = {};
      for (k = 0; k < n; k++) frame_bytes.push_back(8'($urandom));
    end
    send_frame();
    if ($urandom_range(19) == 0) drain_verdicts();
  endtask

  // ------------------------------------------------------- result side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // sample at the edge; values read here are those the block saw
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.match_verdict(out_status, out_fix_time_updated, out_fix_time);
    end
  end

  // watchdog: any handshake on either channel restarts the count
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else                                                     quiet++;
    end
    $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------- main
  initial begin
    int ph;
    int base_bytes;
    int base_frames;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data_byte = '0;
    in_is_last   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();
    base_bytes  = sb.bytes_taken;
    base_frames = sb.frames_closed;

    // phase 0: sender busy, receiver slow; phase 1 the reverse; phase 2 flat out
    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 14; recv_idle_pct = 73; end
        1: begin send_idle_pct = 73; recv_idle_pct = 14; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      while (sb.bytes_taken - base_bytes < RAND_BYTES * (ph + 1) ||
             sb.frames_closed - base_frames < RAND_FRAMES * (ph + 1))
        send_random_frame();
      drain_verdicts();
    end

    in_valid = 1'b0;
    drain_verdicts();
    repeat (DRAIN_CYCLES) @(negedge clk);
    sb.flag_leftovers();

    $display("covered %0d bytes in %0d frames: %0d ok, %0d invalid, %0d checksum fail",
             sb.bytes_taken, sb.frames_closed, sb.n_ok, sb.n_invalid, sb.n_cksum);
    $display("fix time latched %0d times; %0d failure(s) seen",
             sb.n_latched, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
